/* design/assert_macros.svh */
// assertion macros shared by the lfu page replacement rtl
// expects signals named clk and rst in the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, ignored while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lfu_pkg.sv */
// shared types and constants for the lfu page replacement block
// no dependencies; used by lfu_page_replacement
package lfu_pkg;

  // default sizes, overridable on the top level
  localparam int FRAMES_DEF     = 8;
  localparam int PAGES_DEF      = 256;
  localparam int COUNT_BITS_DEF = 16;

  // request field widths
  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 3;
  localparam int FAULT_W = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int CFG_W   = 4;
  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

/* design/lfu_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; used for the per-page history counts
module lfu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/lfu_page_replacement.sv */
// lfu page replacement unit: frame table in registers, history counts in ram
// depends on lfu_pkg, lfu_ram and assert_macros.svh
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_stall    page
//   result    out        out_valid / out_stall  hit, frame, evicted_valid,
//                                               evicted_page, fault_count
//   config    in         apb psel / penable     frames_in_use at byte address 0
//
// a hit or a fill into an empty frame is paced by the history ram
// read-modify-write (read at accept, write back in the cycle after).
// an eviction adds a victim scan: the smallest use count is found by a scan
// of one frame per cycle over the nf managed frames.
// after reset a clearing pass zeroes the history ram; no
// request is taken during it, configuration writes are.
// a result waiting on out_stall holds in the output register; the next request
// is taken while it waits and stops only when its own result is ready.
`include "assert_macros.svh"

module lfu_page_replacement #(
  parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
  parameter int PAGES      = lfu_pkg::PAGES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfu_pkg::PAGE_W-1:0]  page,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [lfu_pkg::FRAME_W-1:0] frame,
  output logic                        evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]  evicted_page,
  output logic [lfu_pkg::FAULT_W-1:0] fault_count
);
  import lfu_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NF_W   = $clog2(FRAMES + 1);
  localparam int HIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CMP_W  = (NF_W > CFG_W) ? NF_W : CFG_W;
  localparam int FO_W   = (FIDX_W < FRAME_W) ? FIDX_W : FRAME_W;
  localparam int FC_W   = (COUNT_BITS < FAULT_W) ? COUNT_BITS : FAULT_W;
  localparam int NPAGE  = 1 << PAGE_W;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  state_t state, state_next;

  // configuration and counters
  logic [CFG_W-1:0]      cfg_frames;
  logic                  cfg_wr;
  logic [HIDX_W-1:0]     clr_addr;
  logic [NF_W-1:0]       frames_filled;
  logic [COUNT_BITS-1:0] faults;

  // frame table
  logic [PAGE_W-1:0]     frame_page [FRAMES];
  logic [COUNT_BITS-1:0] frame_use  [FRAMES];

  // request in flight
  logic [PAGE_W-1:0]     page_q;
  logic [HIDX_W-1:0]     hidx_q;
  logic                  hit_q;
  logic [FIDX_W-1:0]     hit_idx_q;
  logic [COUNT_BITS-1:0] hist_q;

  // eviction scan
  logic [NF_W-1:0]       scan_idx;
  logic [COUNT_BITS-1:0] min_val;
  logic [FIDX_W-1:0]     min_idx;

  // result waiting for the output register
  logic                  res_hit;
  logic [FIDX_W-1:0]     res_frame;
  logic                  res_ev_valid;
  logic [PAGE_W-1:0]     res_ev_page;

  // combinational helpers
  logic [CMP_W-1:0]      cfg_ext;
  logic [NF_W-1:0]       nf;
  logic [NF_W-1:0]       nvalid;
  logic                  room;
  logic                  in_hit;
  logic [FIDX_W-1:0]     in_hit_idx;
  logic                  in_acc;
  logic                  out_free;
  logic                  load_out;
  logic                  scan_more;
  logic [COUNT_BITS-1:0] scan_use;
  logic [COUNT_BITS-1:0] hist_inc;
  logic [HIDX_W-1:0]     hidx_tab [NPAGE];

  // history ram port signals
  logic                  ram_we;
  logic [HIDX_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [HIDX_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // page to history index, worked out at elaboration
  for (genvar g = 0; g < NPAGE; g++) begin : g_hidx
    localparam int HM = g % PAGES;
    assign hidx_tab[g] = HIDX_W'(HM);
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_FRAMES_IN_USE);
  assign prdata = (paddr[PADDR_W-1] == REG_FRAMES_IN_USE) ? 32'(cfg_frames) : '0;

  // managed frame count, clamped to 1..FRAMES
  always_comb begin
    cfg_ext = CMP_W'(cfg_frames);
    if (cfg_frames == '0) begin
      nf = NF_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      nf = NF_W'(FRAMES);
    end else begin
      nf = NF_W'(cfg_frames);
    end
  end

  assign room   = frames_filled < nf;
  assign nvalid = room ? frames_filled : nf;

  // parallel lookup, lowest matching frame wins
  always_comb begin
    in_hit     = 1'b0;
    in_hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((NF_W'(i) < nvalid) && (frame_page[i] == page)) begin
        in_hit     = 1'b1;
        in_hit_idx = FIDX_W'(i);
      end
    end
  end

  assign hist_inc  = sat_inc(ram_rdata);
  assign scan_more = scan_idx < nf;
  assign scan_use  = frame_use[scan_idx[FIDX_W-1:0]];
  assign out_free  = !out_valid || !out_stall;
  assign in_acc    = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == HIDX_W'(PAGES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_next = S_READ;
      end
      S_READ: begin
        if (!hit_q && !room) state_next = S_SCAN;
        else state_next = S_OUT;
      end
      S_SCAN: begin
        if (!scan_more) state_next = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_next = in_acc ? S_READ : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs: handshake and history ram control
  always_comb begin
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hidx_q;
    ram_wdata = hist_inc;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_READ: begin
        ram_we = 1'b1;
      end
      S_OUT: begin
        load_out = out_free;
      end
      S_IDLE, S_SCAN: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
    in_stall  = !((state == S_IDLE) || load_out);
    ram_re    = in_acc;
    ram_raddr = hidx_tab[page];
  end

  lfu_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAGES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cfg_frames    <= CFG_FRAMES_RESET;
      clr_addr      <= '0;
      frames_filled <= '0;
      faults        <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_use[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr) cfg_frames <= pwdata[CFG_W-1:0];
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      // fault count and fill pointer
      if (state == S_READ && !hit_q) begin
        faults <= sat_inc(faults);
        if (room) frames_filled <= frames_filled + 1'b1;
      end
      // use count per frame: bump on hit, 1 on fill, history on eviction
      for (int i = 0; i < FRAMES; i++) begin
        if (state == S_READ && hit_q && hit_idx_q == FIDX_W'(i)) begin
          frame_use[i] <= sat_inc(frame_use[i]);
        end else if (state == S_READ && !hit_q && room && frames_filled == NF_W'(i)) begin
          frame_use[i] <= COUNT_BITS'(1);
        end else if (state == S_SCAN && !scan_more && min_idx == FIDX_W'(i)) begin
          frame_use[i] <= hist_q;
        end
      end
      // output register valid
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    // capture request and lookup
    if (in_acc) begin
      page_q    <= page;
      hidx_q    <= hidx_tab[page];
      hit_q     <= in_hit;
      hit_idx_q <= in_hit_idx;
    end
    // history read back, fill, scan setup
    if (state == S_READ) begin
      hist_q       <= hist_inc;
      res_hit      <= hit_q;
      res_ev_valid <= 1'b0;
      res_ev_page  <= '0;
      res_frame    <= hit_q ? hit_idx_q : frames_filled[FIDX_W-1:0];
      if (!hit_q && room) frame_page[frames_filled[FIDX_W-1:0]] <= page_q;
      scan_idx <= NF_W'(1);
      min_val  <= frame_use[0];
      min_idx  <= '0;
    end
    // victim scan, one frame per cycle, then replace
    if (state == S_SCAN) begin
      if (scan_more) begin
        if (scan_use < min_val) begin
          min_val <= scan_use;
          min_idx <= scan_idx[FIDX_W-1:0];
        end
        scan_idx <= scan_idx + 1'b1;
      end else begin
        res_frame           <= min_idx;
        res_ev_valid        <= 1'b1;
        res_ev_page         <= frame_page[min_idx];
        frame_page[min_idx] <= page_q;
      end
    end
    // output register load
    if (load_out) begin
      hit           <= res_hit;
      frame         <= FRAME_W'(res_frame[FO_W-1:0]);
      evicted_valid <= res_ev_valid;
      evicted_page  <= res_ev_page;
      fault_count   <= FAULT_W'(faults[FC_W-1:0]);
    end
  end

  // checks
  `ASSERT_CLK(a_accept_reads, in_valid && !in_stall |=> state == S_READ, "accept not followed by ram read")
  `ASSERT_CLK(a_filled_bound, frames_filled <= NF_W'(FRAMES), "fill count beyond frame table")
  `ASSERT_CLK(a_hit_no_evict, out_valid |-> !(hit && evicted_valid), "eviction reported on a hit")
  `ASSERT_CLK_ALWAYS(a_clear_stalls, state == S_CLEAR |-> in_stall, "request taken during clearing pass")

endmodule
